>>> hw/rtl/png_csc_pkg.sv
// ----------------------------------------------------------------------------
// PNG chunk stream checker package
// Shared constants, status codes and the result word layout.
// ----------------------------------------------------------------------------
package png_csc_pkg;

  // PNG file signature, first byte in the top bits
  localparam logic [63:0] PngSig   = 64'h8950_4e47_0d0a_1a0a;
  // Reflected CRC-32 polynomial and preset / final xor
  localparam logic [31:0] CrcPoly  = 32'hedb8_8320;
  localparam logic [31:0] CrcOnes  = 32'hffff_ffff;
  // Chunk type of the closing chunk
  localparam logic [31:0] IendType = 32'h4945_4e44;

  // Status codes reported with every result word
  typedef enum logic [2:0] {
    ST_BUSY   = 3'd0,
    ST_GOOD   = 3'd1,
    ST_ACCEPT = 3'd2,
    ST_BADSIG = 3'd3,
    ST_BADCRC = 3'd4,
    ST_TRUNC  = 3'd5
  } status_t;

  // One result word
  typedef struct packed {
    status_t     status;
    logic        in_payload;
    logic [31:0] chunk_type;
    logic [31:0] chunk_length;
    logic        is_end_chunk;
  } result_t;

endpackage

>>> hw/rtl/png_csc_out_buf.sv
// ----------------------------------------------------------------------------
// PNG chunk stream checker output buffer
// Output register plus one skid register, so the producer can hand over a
// new result word in the same cycle the receiver stalls.
// ----------------------------------------------------------------------------
module png_csc_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  png_csc_pkg::result_t push_data,
  output logic                 push_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output png_csc_pkg::result_t out_data
);

  logic                 out_valid_r;
  logic                 skid_valid_r;
  png_csc_pkg::result_t out_data_r;
  png_csc_pkg::result_t skid_data_r;
  logic                 out_take;

  assign out_take   = out_valid_r && out_ready;
  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  // Control: track occupancy of output and skid stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (out_take) begin
          skid_valid_r <= 1'b0;
        end
      end else if (push) begin
        if (out_valid_r && !out_ready) begin
          skid_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: refill output from skid first, else from the producer
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (out_valid_r && !out_ready) begin
        skid_data_r <= push_data;
      end else begin
        out_data_r <= push_data;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held with empty output register");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_ready && out_valid_r && !out_ready) |=> skid_valid_r)
    else $error("word pushed into stalled buffer was not parked");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_ready) |=> (out_valid_r && !skid_valid_r))
    else $error("skid word not moved to output when taken");
`endif

endmodule

>>> hw/rtl/png_chunk_stream_checker_unit.sv
// ----------------------------------------------------------------------------
// PNG chunk stream checker
// Byte-serial check of a PNG stream: signature, chunk framing and CRC-32.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready): one stream byte per word, with
//   in_stream_end set on the last byte of the stream.
//   Result channel (out_valid / out_ready): exactly one result word per
//   input word, in order: status, data-field flag, chunk type and length
//   received so far, and an IEND match flag.
//   Throughput is one byte per clock while in_ready is high. The signature
//   compare, length count and the eight-bit CRC-32 update all run
//   combinationally between the state registers and the output register,
//   which sets that rate. An accepted word's result is registered in the
//   output (or, during a stall, skid) register before it shows on out_valid.
//   Status codes: 0 busy, 1 chunk good, 2 IEND accepted, 3 bad signature,
//   4 bad CRC, 5 truncated. Errors are sticky; after IEND every byte
//   reports accepted.
//   Reset (rst_n low, synchronous) returns to the signature check and
//   empties the output stages.
//   When the receiver stalls, one result waits in the output register and
//   one more in a skid register; in_ready drops only while both are full.
// ----------------------------------------------------------------------------
module png_chunk_stream_checker_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_stream_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic        out_in_payload,
  output logic [31:0] out_chunk_type,
  output logic [31:0] out_chunk_length,
  output logic        out_is_end_chunk
);

  typedef enum logic [6:0] {
    PH_SIG  = 7'b0000001,
    PH_LEN  = 7'b0000010,
    PH_TYPE = 7'b0000100,
    PH_DATA = 7'b0001000,
    PH_CRC  = 7'b0010000,
    PH_DONE = 7'b0100000,
    PH_ERR  = 7'b1000000
  } phase_t;

  // One byte through the reflected CRC-32
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'h000000, b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ png_csc_pkg::CrcPoly) : (v >> 1);
    end
    return v;
  endfunction

  phase_t               phase_r, phase_nxt;
  logic [2:0]           byte_idx_r, byte_idx_nxt;
  logic [31:0]          length_left_r, length_left_nxt;
  logic [31:0]          type_word_r, type_word_nxt;
  logic [31:0]          decl_len_r, decl_len_nxt;
  logic [31:0]          crc_accum_r, crc_accum_nxt;
  logic [31:0]          crc_rcvd_r, crc_rcvd_nxt;
  png_csc_pkg::status_t err_code_r, err_code_nxt;

  logic                 accept;
  logic                 push_ready;
  png_csc_pkg::result_t res;
  png_csc_pkg::result_t out_word;

  logic [7:0]           sig_want;
  logic [31:0]          crc_upd;
  logic [31:0]          len_dec;
  png_csc_pkg::status_t status;
  logic                 payload;
  logic                 live;

  assign accept   = in_valid && push_ready;
  assign in_ready = push_ready;

  // Expected signature byte at the current position
  assign sig_want = 8'(png_csc_pkg::PngSig >> {~byte_idx_r, 3'b000});
  assign crc_upd  = crc_byte(crc_accum_r, in_data_byte);
  assign len_dec  = length_left_r - 32'd1;

  // Advance the parse state by one byte
  always_comb begin
    phase_nxt       = phase_r;
    byte_idx_nxt    = byte_idx_r;
    length_left_nxt = length_left_r;
    type_word_nxt   = type_word_r;
    decl_len_nxt    = decl_len_r;
    crc_accum_nxt   = crc_accum_r;
    crc_rcvd_nxt    = crc_rcvd_r;
    err_code_nxt    = err_code_r;
    status          = png_csc_pkg::ST_BUSY;
    payload         = 1'b0;
    live            = 1'b1;

    case (phase_r)
      PH_SIG: begin
        if (in_data_byte != sig_want || (in_stream_end && byte_idx_r < 3'd7)) begin
          phase_nxt    = PH_ERR;
          err_code_nxt = png_csc_pkg::ST_BADSIG;
          live         = 1'b0;
        end else if (byte_idx_r == 3'd7) begin
          phase_nxt    = PH_LEN;
          byte_idx_nxt = 3'd0;
        end else begin
          byte_idx_nxt = byte_idx_r + 3'd1;
        end
      end
      PH_LEN: begin
        if (byte_idx_r == 3'd0) begin
          decl_len_nxt  = {24'h000000, in_data_byte};
          type_word_nxt = 32'h0;
          crc_accum_nxt = png_csc_pkg::CrcOnes;
        end else begin
          decl_len_nxt = {decl_len_r[23:0], in_data_byte};
        end
        if (byte_idx_r >= 3'd3) begin
          phase_nxt    = PH_TYPE;
          byte_idx_nxt = 3'd0;
        end else begin
          byte_idx_nxt = byte_idx_r + 3'd1;
        end
      end
      PH_TYPE: begin
        type_word_nxt = {type_word_r[23:0], in_data_byte};
        crc_accum_nxt = crc_upd;
        if (byte_idx_r >= 3'd3) begin
          byte_idx_nxt    = 3'd0;
          length_left_nxt = decl_len_r;
          phase_nxt       = (decl_len_r == 32'h0) ? PH_CRC : PH_DATA;
        end else begin
          byte_idx_nxt = byte_idx_r + 3'd1;
        end
      end
      PH_DATA: begin
        payload         = 1'b1;
        crc_accum_nxt   = crc_upd;
        length_left_nxt = len_dec;
        if (len_dec == 32'h0) begin
          phase_nxt    = PH_CRC;
          byte_idx_nxt = 3'd0;
        end
      end
      PH_CRC: begin
        crc_rcvd_nxt = {crc_rcvd_r[23:0], in_data_byte};
        if (byte_idx_r >= 3'd3) begin
          byte_idx_nxt = 3'd0;
          if (crc_rcvd_nxt != ~crc_accum_r) begin
            phase_nxt    = PH_ERR;
            err_code_nxt = png_csc_pkg::ST_BADCRC;
            live         = 1'b0;
          end else if (type_word_r == png_csc_pkg::IendType) begin
            phase_nxt = PH_DONE;
            status    = png_csc_pkg::ST_ACCEPT;
            live      = 1'b0;
          end else begin
            phase_nxt = PH_LEN;
            status    = png_csc_pkg::ST_GOOD;
          end
        end else begin
          byte_idx_nxt = byte_idx_r + 3'd1;
        end
      end
      PH_DONE: begin
        status = png_csc_pkg::ST_ACCEPT;
        live   = 1'b0;
      end
      default: begin
        phase_nxt = PH_ERR;
        live      = 1'b0;
        if (err_code_r == png_csc_pkg::ST_BUSY) begin
          err_code_nxt = png_csc_pkg::ST_TRUNC;
        end
      end
    endcase

    // Drop into truncated when the stream ends mid-parse
    if (live && in_stream_end) begin
      phase_nxt    = PH_ERR;
      err_code_nxt = png_csc_pkg::ST_TRUNC;
    end
    if (phase_nxt == PH_ERR) begin
      status  = err_code_nxt;
      payload = 1'b0;
    end
  end

  // Build the result word from the post-byte state
  always_comb begin
    res.status       = status;
    res.in_payload   = payload;
    res.chunk_type   = type_word_nxt;
    res.chunk_length = decl_len_nxt;
    res.is_end_chunk = (type_word_nxt == png_csc_pkg::IendType);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_SIG;
      byte_idx_r    <= 3'd0;
      length_left_r <= 32'h0;
      type_word_r   <= 32'h0;
      decl_len_r    <= 32'h0;
      crc_accum_r   <= png_csc_pkg::CrcOnes;
      crc_rcvd_r    <= 32'h0;
      err_code_r    <= png_csc_pkg::ST_BUSY;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      byte_idx_r    <= byte_idx_nxt;
      length_left_r <= length_left_nxt;
      type_word_r   <= type_word_nxt;
      decl_len_r    <= decl_len_nxt;
      crc_accum_r   <= crc_accum_nxt;
      crc_rcvd_r    <= crc_rcvd_nxt;
      err_code_r    <= err_code_nxt;
    end
  end

  png_csc_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (res),
    .push_ready (push_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_word)
  );

  assign out_status       = out_word.status;
  assign out_in_payload   = out_word.in_payload;
  assign out_chunk_type   = out_word.chunk_type;
  assign out_chunk_length = out_word.chunk_length;
  assign out_is_end_chunk = out_word.is_end_chunk;

`ifndef SYNTHESIS
  a_data_has_bytes_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (length_left_r != 32'h0))
    else $error("data phase with no bytes left");

  a_err_code_set: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ERR) |-> (err_code_r == png_csc_pkg::ST_BADSIG ||
                             err_code_r == png_csc_pkg::ST_BADCRC ||
                             err_code_r == png_csc_pkg::ST_TRUNC))
    else $error("error phase without an error code");

  a_payload_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_in_payload) |-> (out_status == png_csc_pkg::ST_BUSY))
    else $error("data byte reported with a final status");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE) |=> (phase_r == PH_DONE))
    else $error("left the accepted state");
`endif

endmodule

>>> dv/png_stream_result_check.sv
// ----------------------------------------------------------------------------
// PNG stream result checker
// Watches both channels of the PNG chunk stream checker. Runs its own parse
// of every accepted byte (signature, chunk framing, CRC-32) to predict the
// result word, then compares each delivered word field by field in order.
// ----------------------------------------------------------------------------
module png_stream_result_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_stream_end,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_status,
  input  logic        out_in_payload,
  input  logic [31:0] out_chunk_type,
  input  logic [31:0] out_chunk_length,
  input  logic        out_is_end_chunk,
  output int          mismatches,
  output int          results_left,
  output int          words_checked,
  output int          chunks_passed
);

  typedef enum logic [2:0] {
    P_SIG, P_LEN, P_TYPE, P_DATA, P_CRC, P_DONE, P_ERR
  } parse_phase_t;

  // Parser state mirrored from the byte stream
  parse_phase_t         ph;
  logic [2:0]           idx;
  logic [31:0]          left_cnt;
  logic [31:0]          type_w;
  logic [31:0]          len_w;
  logic [31:0]          crc_run;
  logic [31:0]          crc_got;
  png_csc_pkg::status_t sticky;

  png_csc_pkg::result_t pending_results[$];
  png_csc_pkg::result_t want;

  function automatic logic [31:0] crc32_advance(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] acc;
    acc = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      acc = acc[0] ? ((acc >> 1) ^ png_csc_pkg::CrcPoly) : (acc >> 1);
    end
    return acc;
  endfunction

  // Advance the parse by one byte and build the word it should produce
  function automatic png_csc_pkg::result_t next_result_for_byte(input logic [7:0] b,
                                                                input logic last_byte);
    png_csc_pkg::status_t st;
    logic                 pay;
    logic                 live;
    logic [7:0]           sig_b;
    png_csc_pkg::result_t r;
    st   = png_csc_pkg::ST_BUSY;
    pay  = 1'b0;
    live = 1'b1;
    case (ph)
      P_SIG: begin
        sig_b = png_csc_pkg::PngSig[63 - 8 * int'(idx) -: 8];
        if (b != sig_b || (last_byte && idx < 3'd7)) begin
          ph = P_ERR;
          sticky = png_csc_pkg::ST_BADSIG;
          live = 1'b0;
        end else if (idx == 3'd7) begin
          ph = P_LEN;
          idx = 3'd0;
        end else begin
          idx++;
        end
      end
      P_LEN: begin
        if (idx == 3'd0) begin
          len_w   = {24'd0, b};
          type_w  = 32'd0;
          crc_run = png_csc_pkg::CrcOnes;
        end else begin
          len_w = {len_w[23:0], b};
        end
        if (idx == 3'd3) begin
          ph = P_TYPE;
          idx = 3'd0;
        end else begin
          idx++;
        end
      end
      P_TYPE: begin
        type_w  = {type_w[23:0], b};
        crc_run = crc32_advance(crc_run, b);
        if (idx == 3'd3) begin
          idx = 3'd0;
          left_cnt = len_w;
          ph = (len_w == 32'd0) ? P_CRC : P_DATA;
        end else begin
          idx++;
        end
      end
      P_DATA: begin
        pay = 1'b1;
        crc_run = crc32_advance(crc_run, b);
        left_cnt = left_cnt - 32'd1;
        if (left_cnt == 32'd0) begin
          ph = P_CRC;
          idx = 3'd0;
        end
      end
      P_CRC: begin
        crc_got = {crc_got[23:0], b};
        if (idx == 3'd3) begin
          idx = 3'd0;
          if (crc_got != ~crc_run) begin
            ph = P_ERR;
            sticky = png_csc_pkg::ST_BADCRC;
            live = 1'b0;
          end else if (type_w == png_csc_pkg::IendType) begin
            ph = P_DONE;
            st = png_csc_pkg::ST_ACCEPT;
            live = 1'b0;
            chunks_passed++;
          end else begin
            ph = P_LEN;
            st = png_csc_pkg::ST_GOOD;
            chunks_passed++;
          end
        end else begin
          idx++;
        end
      end
      P_DONE: begin
        st = png_csc_pkg::ST_ACCEPT;
        live = 1'b0;
      end
      default: begin
        ph = P_ERR;
        live = 1'b0;
        if (sticky == png_csc_pkg::ST_BUSY) sticky = png_csc_pkg::ST_TRUNC;
      end
    endcase
    // A stream that stops before the closing chunk is truncated
    if (live && last_byte) begin
      ph = P_ERR;
      sticky = png_csc_pkg::ST_TRUNC;
    end
    if (ph == P_ERR) begin
      st = sticky;
      pay = 1'b0;
    end
    r.status       = st;
    r.in_payload   = pay;
    r.chunk_type   = type_w;
    r.chunk_length = len_w;
    r.is_end_chunk = (type_w == png_csc_pkg::IendType);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] expd);
    $display("[%0t] result word %0d: %s got %h, expected %h",
             $realtime, words_checked, what, got, expd);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ph       = P_SIG;
      idx      = 3'd0;
      left_cnt = 32'd0;
      type_w   = 32'd0;
      len_w    = 32'd0;
      crc_run  = png_csc_pkg::CrcOnes;
      crc_got  = 32'd0;
      sticky   = png_csc_pkg::ST_BUSY;
      pending_results.delete();
      results_left <= 0;
    end else begin
      // Retire the oldest prediction against each delivered word
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected word, status", 32'(out_status), 32'd0);
        end else begin
          want = pending_results.pop_front();
          words_checked++;
          if (out_status !== want.status)
            report_mismatch("status", 32'(out_status), 32'(want.status));
          if (out_in_payload !== want.in_payload)
            report_mismatch("in_payload", 32'(out_in_payload), 32'(want.in_payload));
          if (out_chunk_type !== want.chunk_type)
            report_mismatch("chunk_type", out_chunk_type, want.chunk_type);
          if (out_chunk_length !== want.chunk_length)
            report_mismatch("chunk_length", out_chunk_length, want.chunk_length);
          if (out_is_end_chunk !== want.is_end_chunk)
            report_mismatch("is_end_chunk", 32'(out_is_end_chunk), 32'(want.is_end_chunk));
        end
      end
      // Predict the word for each accepted byte
      if (in_valid && in_ready) begin
        pending_results.push_back(next_result_for_byte(in_data_byte, in_stream_end));
      end
      results_left <= pending_results.size();
    end
  end

endmodule

>>> dv/png_chunk_stream_checker_unit_tb.sv
// ----------------------------------------------------------------------------
// PNG chunk stream checker testbench
// Builds one PNG byte stream: signature, a zero-length chunk, about a thousand
// bytes of random chunks with correct CRCs, then one randomly chosen ending
// (IEND, bad CRC, cut stream, end on a good chunk, huge length) and trailing
// bytes; or just a bad signature and random bytes. Both channels stall at
// random; the result checker beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
module png_chunk_stream_checker_unit_tb;

  localparam int ClkPeriod     = 20;
  localparam int BodyBytes     = 1100;
  localparam int TailQuiet     = 150;
  localparam int LongStall     = 64;
  localparam int DrainCycles   = 8;
  localparam int TimeoutCycles = 200_000;

  typedef enum {
    FIN_ACCEPT, FIN_IEND_BADCRC, FIN_BADCRC, FIN_CUT, FIN_GOOD_LAST, FIN_HUGE_LEN,
    FIN_BADSIG
  } stream_ending_t;

  typedef struct packed {
    logic       last;
    logic [7:0] b;
  } stream_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_stream_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic        out_in_payload;
  logic [31:0] out_chunk_type;
  logic [31:0] out_chunk_length;
  logic        out_is_end_chunk;

  int mismatches;
  int results_left;
  int words_checked;
  int chunks_passed;

  stream_word_t   png_bytes[$];
  stream_ending_t ending;
  int             words_sent = 0;
  int             stall_after = 0;
  bit             stall_done = 1'b0;
  bit             calm = 1'b0;

  png_chunk_stream_checker_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_stream_end   (in_stream_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_in_payload  (out_in_payload),
    .out_chunk_type  (out_chunk_type),
    .out_chunk_length(out_chunk_length),
    .out_is_end_chunk(out_is_end_chunk)
  );

  png_stream_result_check chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_stream_end   (in_stream_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_in_payload  (out_in_payload),
    .out_chunk_type  (out_chunk_type),
    .out_chunk_length(out_chunk_length),
    .out_is_end_chunk(out_is_end_chunk),
    .mismatches      (mismatches),
    .results_left    (results_left),
    .words_checked   (words_checked),
    .chunks_passed   (chunks_passed)
  );

  always begin
    #(ClkPeriod / 2) clk = 1'b1;
    #(ClkPeriod / 2) clk = 1'b0;
  end

  // Stream generation -------------------------------------------------------

  function automatic logic [31:0] crc32_add(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] acc;
    acc = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      acc = acc[0] ? ((acc >> 1) ^ png_csc_pkg::CrcPoly) : (acc >> 1);
    end
    return acc;
  endfunction

  function automatic logic [31:0] random_chunk_type();
    logic [31:0] t;
    do begin
      if ($urandom_range(0, 3) != 0) begin
        for (int k = 0; k < 4; k++)
          t[8*k +: 8] = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
      end else begin
        t = $urandom();
      end
    end while (t == png_csc_pkg::IendType);
    return t;
  endfunction

  // Mostly short data fields, now and then a longer one
  function automatic logic [31:0] random_length();
    if ($urandom_range(0, 9) == 0) return $urandom_range(17, 80);
    return $urandom_range(0, 16);
  endfunction

  task automatic add_byte(input logic [7:0] v, input logic l);
    png_bytes.push_back({l, v});
  endtask

  task automatic add_noise(input int n);
    for (int i = 0; i < n; i++)
      add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
  endtask

  // Emit the signature; bad_at < 8 breaks it there, by a wrong byte or an early end
  task automatic add_signature(input int bad_at, input bit cut_only);
    logic [7:0] sb;
    for (int i = 0; i < 8; i++) begin
      sb = png_csc_pkg::PngSig[63 - 8*i -: 8];
      if (i == bad_at) begin
        if (cut_only) add_byte(sb, 1'b1);
        else add_byte(sb ^ 8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)));
        return;
      end
      add_byte(sb, 1'b0);
    end
  endtask

  // Emit one chunk: length, type, random data, CRC; optionally corrupt the CRC,
  // end the stream at byte cut_pos, or flag the last byte as stream end
  task automatic add_chunk(input logic [31:0] ctype, input logic [31:0] dlen,
                           input bit bad_crc, input int cut_pos, input bit end_on_last);
    logic [7:0]  bytes_q[$];
    logic [31:0] crc;
    logic [7:0]  d;
    crc = png_csc_pkg::CrcOnes;
    for (int i = 3; i >= 0; i--) bytes_q.push_back(dlen[8*i +: 8]);
    for (int i = 3; i >= 0; i--) begin
      bytes_q.push_back(ctype[8*i +: 8]);
      crc = crc32_add(crc, ctype[8*i +: 8]);
    end
    for (int i = 0; i < dlen && (cut_pos < 0 || bytes_q.size() <= cut_pos); i++) begin
      case ($urandom_range(0, 7))
        0:       d = 8'h00;
        1:       d = 8'hff;
        default: d = 8'($urandom_range(0, 255));
      endcase
      bytes_q.push_back(d);
      crc = crc32_add(crc, d);
    end
    crc = ~crc;
    if (bad_crc) crc ^= 32'd1 << $urandom_range(0, 31);
    for (int i = 3; i >= 0; i--) bytes_q.push_back(crc[8*i +: 8]);
    for (int i = 0; i < bytes_q.size(); i++) begin
      if (i == cut_pos) begin
        add_byte(bytes_q[i], 1'b1);
        return;
      end
      add_byte(bytes_q[i], end_on_last && i == bytes_q.size() - 1);
    end
  endtask

  // Receiver: random holds, one long hold to back up the input, none at the tail
  initial begin : result_sink
    int gap;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!stall_done && words_sent >= stall_after) begin
        out_ready <= 1'b0;
        repeat (LongStall) @(posedge clk);
        stall_done = 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        gap = $urandom_range(1, 9);
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : watchdog
    #(ClkPeriod * TimeoutCycles);
    $display("png_chunk_stream_checker_unit regression: fail");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] dlen;
    int          gap;
    case ($urandom_range(0, 9))
      0:       ending = FIN_BADSIG;
      3:       ending = FIN_IEND_BADCRC;
      4:       ending = FIN_BADCRC;
      5, 6:    ending = FIN_CUT;
      7:       ending = FIN_GOOD_LAST;
      8:       ending = FIN_HUGE_LEN;
      default: ending = FIN_ACCEPT;
    endcase

    // Build the whole stream up front
    if (ending == FIN_BADSIG) begin
      add_signature($urandom_range(0, 7), 1'($urandom_range(0, 1)));
    end else begin
      add_signature(8, 1'b0);
      // zero-length chunk whose type is one letter away from IEND
      add_chunk(32'h4945_4e45, 32'd0, 1'b0, -1, 1'b0);
      while (png_bytes.size() < BodyBytes)
        add_chunk(random_chunk_type(), random_length(), 1'b0, -1, 1'b0);
      case (ending)
        FIN_ACCEPT:
          add_chunk(png_csc_pkg::IendType,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0,
                    1'b0, -1, 1'($urandom_range(0, 1)));
        FIN_IEND_BADCRC:
          add_chunk(png_csc_pkg::IendType, 32'd0, 1'b1, -1, 1'($urandom_range(0, 1)));
        FIN_BADCRC:
          add_chunk(random_chunk_type(), random_length(), 1'b1, -1,
                    1'($urandom_range(0, 1)));
        FIN_CUT: begin
          dlen = random_length();
          add_chunk(random_chunk_type(), dlen, 1'b0, $urandom_range(0, 11 + dlen), 1'b0);
        end
        FIN_GOOD_LAST:
          add_chunk(random_chunk_type(), random_length(), 1'b0, -1, 1'b1);
        default:
          add_chunk(random_chunk_type(), $urandom() | 32'h8000_0000, 1'b0,
                    $urandom_range(8, 72), 1'b0);
      endcase
    end
    // Trailing bytes; a short stream is padded to full length
    add_noise((png_bytes.size() < BodyBytes) ? BodyBytes + 100 - png_bytes.size() : 24);
    stall_after = (png_bytes.size() > 600) ? 300 : png_bytes.size() / 3;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Send every word, with random gaps outside the quiet tail
    for (int i = 0; i < png_bytes.size(); i++) begin
      calm = (i >= png_bytes.size() - TailQuiet);
      if (!calm && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        gap = $urandom_range(1, 9);
        repeat (gap) @(posedge clk);
      end
      in_valid      <= 1'b1;
      in_data_byte  <= png_bytes[i].b;
      in_stream_end <= png_bytes[i].last;
      do @(posedge clk); while (!in_ready);
      words_sent++;
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then wait for any stray result words
    while (results_left != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d stream bytes ending in %s;", words_sent, ending.name());
    $display("checked %0d result words, %0d chunks passed CRC.",
             words_checked, chunks_passed);
    if (results_left != 0) $display("%0d result words never arrived", results_left);
    if (mismatches == 0 && results_left == 0) begin
      $display("png_chunk_stream_checker_unit regression: pass");
    end else begin
      $display("png_chunk_stream_checker_unit regression: fail");
    end
    $finish;
  end

endmodule
